// ===== rtl/fnas_pkg.sv =====
// ============================================================================
// fnas_pkg: shared types and constants for the four-neighbor average stencil
// Pixel width, register codes, reset values and the result beat layout.
// ============================================================================
package fnas_pkg;

    // Pixel and result field widths.
    localparam int PIXEL_W  = 16;
    localparam int ROW_W    = 12;
    localparam int COLOUT_W = 11;
    localparam int LW_W     = 12;
    localparam int FH_W     = 13;
    localparam int TDATA_W  = 40;

    // Register reset values and legal bounds.
    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd1080;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1920;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN = 13'd3;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX = 13'd4096;
    localparam int              LINE_WIDTH_MIN   = 3;

    // Register map, indexed by paddr[2].
    typedef enum logic [0:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // One result beat.
    typedef struct packed {
        logic                frame_end;
        logic [COLOUT_W-1:0] center_col;
        logic [ROW_W-1:0]    center_row;
        logic [PIXEL_W-1:0]  average;
    } result_t;

endpackage

// ===== rtl/four_neighbour_average_stencil_top.sv =====
// ============================================================================
// four_neighbour_average_stencil_top: four-neighbor mean over a pixel stream
// Raster-order pixels in, one (up + down + left + right) >> 2 result out for
// every interior center pixel, with its row, column and an end-of-frame mark.
// ============================================================================
//
//  Channel   Direction  Beat contents (low bit first)
//  -------   ---------  --------------------------------------------------
//  s_        in         tdata: pixel[15:0]
//  m_        out        tdata: average[15:0], center_row[27:16],
//                              center_col[38:28], zero pad[39]; tlast: frame_end
//  APB       in/out     line_width at 0x0, frame_height at 0x4
//
//  The block takes one pixel beat per clock while m_ is not stalled. Both
//  line memories are read ahead at the column that the next pixel will hit,
//  so their registered read is hidden and each pixel is read, summed and
//  written back in its own cycle. A result appears on m_ the cycle after the
//  pixel beat that completes it. Reset is synchronous and needs no clearing
//  pass: the line memories hold garbage until the first two rows of a frame
//  have passed, and those rows give no results. A stall on m_ holds the
//  result register and lowers s_tready until the waiting beat is taken.
//
module four_neighbour_average_stencil_top #(
    parameter int MAX_LINE = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Pixel input; tdata: pixel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fnas_pkg::PIXEL_W-1:0]       s_tdata,
    // Results; tdata: average, center_row, center_col, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fnas_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fnas_pkg::*;

    // Column index width for the memories, and a working width that holds
    // a column plus two as well as the 12-bit line width register.
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int CW1   = $clog2(MAX_LINE + 1) + 1;
    localparam int WW    = (CW1 > 13) ? CW1 : 13;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_LINE);
    localparam logic [WW-1:0] W_MIN = WW'(LINE_WIDTH_MIN);

    // Clamp the programmed line width into [3, MAX_LINE].
    function automatic logic [WW-1:0] clamp_width(input logic [LW_W-1:0] v);
        logic [WW-1:0] e;
        e = WW'(v);
        if (e < W_MIN) begin
            return W_MIN;
        end else if (e > W_MAX) begin
            return W_MAX;
        end
        return e;
    endfunction

    // Clamp the programmed frame height into [3, 4096].
    function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] v);
        if (v < FRAME_HEIGHT_MIN) begin
            return FRAME_HEIGHT_MIN;
        end else if (v > FRAME_HEIGHT_MAX) begin
            return FRAME_HEIGHT_MAX;
        end
        return v;
    endfunction

    // A stored column at or beyond the line width wraps to column zero.
    function automatic logic [COL_W-1:0] norm_col(input logic [COL_W-1:0] col,
                                                  input logic [WW-1:0]    w);
        return (WW'(col) >= w) ? '0 : col;
    endfunction

    // The row follows a column wrap, and itself wraps at the frame height.
    function automatic logic [ROW_W-1:0] norm_row(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [WW-1:0]    w,
                                                  input logic [FH_W-1:0]  h);
        logic [FH_W-1:0] r;
        r = FH_W'(row) + ((WW'(col) >= w) ? FH_W'(1) : FH_W'(0));
        return (r >= h) ? '0 : r[ROW_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [LW_W-1:0]    lw_reg, lw_next;
    logic [FH_W-1:0]    fh_reg, fh_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PIXEL_W-1:0] middle_center_reg, middle_center_next;
    logic               m_tvalid_reg, m_tvalid_next;
    result_t            result_reg, result_next;

    // Line memories and their registered read data.
    logic [PIXEL_W-1:0] upper_line_mem  [MAX_LINE];
    logic [PIXEL_W-1:0] middle_line_mem [MAX_LINE];
    logic [PIXEL_W-1:0] upper_rd_reg;
    logic [PIXEL_W-1:0] middle_rd_reg;
    logic [PIXEL_W-1:0] right_rd_reg;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    logic accept;
    logic cfg_wr;

    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite;

    // ------------------------------------------------------------------------
    // Current position and stencil arithmetic
    // ------------------------------------------------------------------------
    logic [WW-1:0]        w_eff;
    logic [FH_W-1:0]      h_eff;
    logic [COL_W-1:0]     c_cur;
    logic [ROW_W-1:0]     r_cur;
    logic [WW-1:0]        c_inc;
    logic [FH_W-1:0]      r_inc;
    logic                 row_wrap;
    logic                 hit;
    logic [PIXEL_W+1:0]   sum;
    logic [COL_W-1:0]     col_step;
    logic [ROW_W-1:0]     row_step;

    always_comb begin
        w_eff    = clamp_width(lw_reg);
        h_eff    = clamp_height(fh_reg);
        c_cur    = norm_col(col_reg, w_eff);
        r_cur    = norm_row(col_reg, row_reg, w_eff, h_eff);
        c_inc    = WW'(c_cur) + WW'(1);
        r_inc    = FH_W'(r_cur) + FH_W'(1);
        row_wrap = (c_inc >= w_eff);

        // Interior center at (r-1, c): needs two rows above, a left and a right neighbor.
        hit = (r_cur >= ROW_W'(2)) && (c_cur != '0) && (c_inc < w_eff);

        // Up, down (new pixel), left (previous middle), right (read ahead).
        sum = (PIXEL_W+2)'(upper_rd_reg) + (PIXEL_W+2)'(s_tdata)
            + (PIXEL_W+2)'(middle_center_reg) + (PIXEL_W+2)'(right_rd_reg);

        col_step = row_wrap ? '0 : c_inc[COL_W-1:0];
        if (!row_wrap) begin
            row_step = r_cur;
        end else if (r_inc >= h_eff) begin
            row_step = '0;
        end else begin
            row_step = r_inc[ROW_W-1:0];
        end
    end

    always_comb begin
        result_next.average    = sum[PIXEL_W+1:2];
        result_next.center_row = r_cur - ROW_W'(1);
        result_next.center_col = COLOUT_W'(WW'(c_cur));
        result_next.frame_end  = (r_inc == h_eff) && (c_inc == w_eff - WW'(1));
    end

    // ------------------------------------------------------------------------
    // Next-state values
    // ------------------------------------------------------------------------
    always_comb begin
        lw_next = lw_reg;
        fh_next = fh_reg;
        if (cfg_wr) begin
            case (reg_index_t'(paddr[2]))
                REG_LINE_WIDTH:   lw_next = pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = pwdata[FH_W-1:0];
                default:          ;
            endcase
        end

        col_next           = accept ? col_step : col_reg;
        row_next           = accept ? row_step : row_reg;
        middle_center_next = accept ? middle_rd_reg : middle_center_reg;

        if (accept) begin
            m_tvalid_next = hit;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Read-ahead addresses: the column the next pixel will land on, under
    // the bounds that will be in force next cycle, and the column after it.
    // The write this cycle is always to a different column.
    // ------------------------------------------------------------------------
    logic [COL_W-1:0] rd_addr_a;
    logic [COL_W-1:0] rd_addr_b;
    logic [WW-1:0]    rd_addr_b_ext;

    always_comb begin
        rd_addr_a     = norm_col(col_next, clamp_width(lw_next));
        rd_addr_b_ext = WW'(rd_addr_a) + WW'(1);
        rd_addr_b     = (rd_addr_b_ext < W_MAX) ? rd_addr_b_ext[COL_W-1:0] : '0;
    end

    // ------------------------------------------------------------------------
    // Line memories: the old middle row moves up, the new pixel takes its place.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            upper_line_mem[c_cur]  <= middle_rd_reg;
            middle_line_mem[c_cur] <= s_tdata;
        end
        upper_rd_reg  <= upper_line_mem[rd_addr_a];
        middle_rd_reg <= middle_line_mem[rd_addr_a];
        right_rd_reg  <= middle_line_mem[rd_addr_b];
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg            <= LINE_WIDTH_RST;
            fh_reg            <= FRAME_HEIGHT_RST;
            col_reg           <= '0;
            row_reg           <= '0;
            middle_center_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            lw_reg            <= lw_next;
            fh_reg            <= fh_next;
            col_reg           <= col_next;
            row_reg           <= row_next;
            middle_center_reg <= middle_center_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // The result register loads only when the output slot is free.
    always_ff @(posedge aclk) begin
        if (accept && hit) begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg.center_col, result_reg.center_row,
                       result_reg.average};
    assign m_tlast  = result_reg.frame_end;
    assign pready   = 1'b1;

    always_comb begin
        case (reg_index_t'(paddr[2]))
            REG_LINE_WIDTH:   prdata = 32'(lw_reg);
            REG_FRAME_HEIGHT: prdata = 32'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The read-ahead never targets the column being written back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_wr) |-> (rd_addr_a != c_cur && rd_addr_b != c_cur))
    else $error("line memory read-ahead collides with write-back column");

    // A result only ever starts from an accepted pixel beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(accept))
    else $error("result appeared without an input beat");

    // Results are interior centers, never on the top row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (result_reg.center_row != '0))
    else $error("result reported for a top-row center");

endmodule
